### hdl/mnmf_pkg.sv
// ----------------------------------------------------------------------------
// mnmf_pkg: shared constants and types
// Sizes of the voxel store, value coding and the memory request bundle.
// ----------------------------------------------------------------------------
package mnmf_pkg;

    localparam int MAX_DIM     = 64;
    localparam int VALUE_BITS  = 16;
    localparam int COORD_BITS  = $clog2(MAX_DIM);
    localparam int DIM_BITS    = 7;
    localparam int ADDR_BITS   = 3 * COORD_BITS;
    localparam int SLICE_BITS  = 2 * COORD_BITS + 1;
    localparam int SUM_BITS    = VALUE_BITS + 5;
    localparam int CNT_BITS    = 5;
    localparam int PASS_BITS   = 8;

    localparam logic [VALUE_BITS-1:0] UNSET_CODE = VALUE_BITS'(1) << (VALUE_BITS - 2);
    localparam logic [ADDR_BITS-1:0]  ADDR_LAST  = {ADDR_BITS{1'b1}};
    localparam logic [DIM_BITS-1:0]   DIM_MAX    = DIM_BITS'(MAX_DIM);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_DEPTH  = 2'd2,
        REG_PASSES = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [VALUE_BITS-1:0] wr_data;
    } mem_req_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage

### hdl/masked_neighbour_mean_fill_core.sv
// ----------------------------------------------------------------------------
// masked_neighbour_mean_fill_core: masked neighbor mean hole filling
// Two voxel banks, host write/read access and a multi-pass fill engine.
//
//   channel  signals                                  direction
//   command  start, busy, kind, voxel_addr,            in (busy out)
//            voxel_value
//   result   done, read_value, run_done                out, one-cycle strobe
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// Write and read items are taken whenever the core is not busy; a read
// result is strobed the next cycle. A run holds busy while every pass
// sweeps the whole store through the single read port of the source bank;
// each unset interior voxel also reads its window of 9 or 27 neighbors and,
// when any neighbor is set, waits for the serial divider. No clearing after
// reset.
// Results cannot be stalled; done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
module masked_neighbour_mean_fill_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [mnmf_pkg::ADDR_BITS-1:0]  voxel_addr,
    input  logic [mnmf_pkg::VALUE_BITS-1:0] voxel_value,
    output logic                            done,
    output logic [mnmf_pkg::VALUE_BITS-1:0] read_value,
    output logic                            run_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);

    logic [mnmf_pkg::DIM_BITS-1:0]   w_reg, h_reg, d_reg;
    logic [mnmf_pkg::PASS_BITS-1:0]  pass_reg;
    logic                            rd_pend_reg;
    logic                            rd_bank_reg;

    logic                            accept, host_wr, host_rd, run_start;
    logic                            eng_busy, eng_done, bank;
    mnmf_pkg::mem_req_t              req;
    logic [mnmf_pkg::VALUE_BITS-1:0] rdata_a, rdata_b, src_data;
    logic                            we_a, we_b, re_a, re_b;
    logic [mnmf_pkg::ADDR_BITS-1:0]  waddr, raddr;
    logic [mnmf_pkg::VALUE_BITS-1:0] wdata;

    assign accept    = start && !eng_busy;
    assign host_wr   = accept && (kind == mnmf_pkg::KIND_WRITE);
    assign host_rd   = accept && (kind == mnmf_pkg::KIND_READ);
    assign run_start = accept && (kind == mnmf_pkg::KIND_RUN);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= mnmf_pkg::DIM_BITS'(64);
            h_reg       <= mnmf_pkg::DIM_BITS'(64);
            d_reg       <= mnmf_pkg::DIM_BITS'(64);
            pass_reg    <= mnmf_pkg::PASS_BITS'(5);
            rd_pend_reg <= 1'b0;
            rd_bank_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= host_rd;
            rd_bank_reg <= bank;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mnmf_pkg::REG_WIDTH:  w_reg    <= cfg_data[mnmf_pkg::DIM_BITS-1:0];
                    mnmf_pkg::REG_HEIGHT: h_reg    <= cfg_data[mnmf_pkg::DIM_BITS-1:0];
                    mnmf_pkg::REG_DEPTH:  d_reg    <= cfg_data[mnmf_pkg::DIM_BITS-1:0];
                    mnmf_pkg::REG_PASSES: pass_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    mnmf_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (run_start),
        .cfg_w      (w_reg),
        .cfg_h      (h_reg),
        .cfg_d      (d_reg),
        .cfg_passes (pass_reg),
        .src_data   (src_data),
        .req        (req),
        .bank       (bank),
        .busy       (eng_busy),
        .done       (eng_done)
    );

    // engine reads the current bank and writes the other; host uses the current
    always_comb
    begin
        if (eng_busy)
        begin
            waddr = req.wr_addr;
            wdata = req.wr_data;
            raddr = req.rd_addr;
            we_a  = req.wr_en && bank;
            we_b  = req.wr_en && !bank;
            re_a  = req.rd_en && !bank;
            re_b  = req.rd_en && bank;
        end
        else
        begin
            waddr = voxel_addr;
            wdata = voxel_value;
            raddr = voxel_addr;
            we_a  = host_wr && !bank;
            we_b  = host_wr && bank;
            re_a  = host_rd && !bank;
            re_b  = host_rd && bank;
        end
    end

    mnmf_ram #(
        .ADDR_W (mnmf_pkg::ADDR_BITS),
        .DATA_W (mnmf_pkg::VALUE_BITS)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re_a),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    mnmf_ram #(
        .ADDR_W (mnmf_pkg::ADDR_BITS),
        .DATA_W (mnmf_pkg::VALUE_BITS)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re_b),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    assign src_data   = bank ? rdata_b : rdata_a;
    assign busy       = eng_busy;
    assign done       = rd_pend_reg || eng_done;
    assign run_done   = eng_done;
    assign read_value = rd_pend_reg ? (rd_bank_reg ? rdata_b : rdata_a) : '0;

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pend_reg && eng_done))
        else $error("read result and run result in the same cycle");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        run_start |=> busy)
        else $error("run item accepted without going busy");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(eng_done))
        else $error("run ended without a done strobe");

endmodule

### hdl/mnmf_ram.sv
// ----------------------------------------------------------------------------
// mnmf_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mnmf_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mnmf_div.sv
// ----------------------------------------------------------------------------
// mnmf_div: iterative unsigned divider
// Restoring division of the neighbor sum by the neighbor count, one bit a cycle.
// ----------------------------------------------------------------------------
module mnmf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mnmf_pkg::SUM_BITS-1:0] dividend,
    input  logic [mnmf_pkg::CNT_BITS-1:0] divisor,
    output logic                          done,
    output logic [mnmf_pkg::SUM_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(mnmf_pkg::SUM_BITS + 1);

    logic [mnmf_pkg::SUM_BITS-1:0] quo_reg, quo_next;
    logic [mnmf_pkg::CNT_BITS:0]   rem_reg, rem_next;
    logic [mnmf_pkg::CNT_BITS-1:0] dvs_reg, dvs_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [mnmf_pkg::CNT_BITS+1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[mnmf_pkg::SUM_BITS-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_BITS'(mnmf_pkg::SUM_BITS);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // shift one dividend bit into the remainder, subtract when it fits
            if (trial >= {2'b00, dvs_reg})
            begin
                rem_next = (mnmf_pkg::CNT_BITS + 1)'(trial - {2'b00, dvs_reg});
                quo_next = {quo_reg[mnmf_pkg::SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[mnmf_pkg::CNT_BITS:0];
                quo_next = {quo_reg[mnmf_pkg::SUM_BITS-2:0], 1'b0};
            end
            step_next = step_reg - STEP_BITS'(1);
            if (step_reg == STEP_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/mnmf_engine.sv
// ----------------------------------------------------------------------------
// mnmf_engine: fill pass sequencer
// Sweeps the source bank, gathers set neighbors of unset interior voxels,
// and writes every entry to the other bank; flips banks after each pass.
// ----------------------------------------------------------------------------
module mnmf_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mnmf_pkg::DIM_BITS-1:0]   cfg_w,
    input  logic [mnmf_pkg::DIM_BITS-1:0]   cfg_h,
    input  logic [mnmf_pkg::DIM_BITS-1:0]   cfg_d,
    input  logic [mnmf_pkg::PASS_BITS-1:0]  cfg_passes,
    input  logic [mnmf_pkg::VALUE_BITS-1:0] src_data,
    output mnmf_pkg::mem_req_t              req,
    output logic                            bank,
    output logic                            busy,
    output logic                            done
);

    typedef enum logic [2:0] {
        E_IDLE, E_CRD, E_CCHK, E_NRD, E_NACC, E_DIV, E_ADV, E_DONE
    } estate_t;

    localparam int CB = mnmf_pkg::COORD_BITS;
    localparam int DB = mnmf_pkg::DIM_BITS;
    localparam int AB = mnmf_pkg::ADDR_BITS;

    estate_t                         state_reg, state_next;
    logic                            bank_reg, bank_next;
    logic [mnmf_pkg::PASS_BITS-1:0]  pass_reg, pass_next;
    logic [AB-1:0]                   addr_reg, addr_next;
    logic [CB-1:0]                   x_reg, x_next, y_reg, y_next;
    logic [DB-1:0]                   z_reg, z_next;
    logic [DB-1:0]                   w_reg, w_next, h_reg, h_next, d_reg, d_next;
    logic [mnmf_pkg::SLICE_BITS-1:0] slice_reg, slice_next;
    logic [AB-1:0]                   base_reg, base_next;
    logic [1:0]                      nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic [mnmf_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic [mnmf_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                            three_d, interior, hit, last_nb;
    logic [AB-1:0]                   w_off, s_off, naddr;
    logic [DB-1:0]                   x_ext, y_ext;
    logic [mnmf_pkg::SUM_BITS-1:0]   sum_add;
    logic [mnmf_pkg::CNT_BITS-1:0]   cnt_add;
    logic [1:0]                      nz_max;
    logic                            div_start, div_done;
    logic [mnmf_pkg::SUM_BITS-1:0]   div_q;

    mnmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (cnt_add),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        three_d = d_reg > DB'(2);
        nz_max  = three_d ? 2'd2 : 2'd0;
        x_ext   = {1'b0, x_reg};
        y_ext   = {1'b0, y_reg};
        interior = (w_reg >= DB'(3)) && (h_reg >= DB'(3)) && (z_reg < d_reg)
                && (x_reg != '0) && (x_ext + DB'(1) < w_reg)
                && (y_reg != '0) && (y_ext + DB'(1) < h_reg)
                && (!three_d || ((z_reg != '0) && (z_reg + DB'(1) < d_reg)));

        case (ny_reg)
            2'd1:    w_off = AB'(w_reg);
            2'd2:    w_off = AB'({w_reg, 1'b0});
            default: w_off = '0;
        endcase
        case (nz_reg)
            2'd1:    s_off = AB'(slice_reg);
            2'd2:    s_off = AB'({slice_reg, 1'b0});
            default: s_off = '0;
        endcase
        naddr   = base_reg + AB'(nx_reg) + w_off + s_off;
        hit     = src_data != mnmf_pkg::UNSET_CODE;
        sum_add = sum_reg + (hit ? mnmf_pkg::SUM_BITS'(src_data) : '0);
        cnt_add = cnt_reg + (hit ? mnmf_pkg::CNT_BITS'(1) : '0);
        last_nb = (nx_reg == 2'd2) && (ny_reg == 2'd2) && (nz_reg == nz_max);
    end

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        pass_next  = pass_reg;
        addr_next  = addr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        d_next     = d_reg;
        slice_next = slice_reg;
        base_next  = base_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        nz_next    = nz_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        div_start  = 1'b0;
        req        = '0;
        req.wr_addr = addr_reg;
        req.rd_addr = addr_reg;

        case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    w_next     = mnmf_pkg::clamp_dim(cfg_w);
                    h_next     = mnmf_pkg::clamp_dim(cfg_h);
                    d_next     = mnmf_pkg::clamp_dim(cfg_d);
                    slice_next = mnmf_pkg::SLICE_BITS'(mnmf_pkg::clamp_dim(cfg_w)
                                 * mnmf_pkg::clamp_dim(cfg_h));
                    pass_next  = cfg_passes;
                    addr_next  = '0;
                    x_next     = '0;
                    y_next     = '0;
                    z_next     = '0;
                    state_next = (cfg_passes == '0) ? E_DONE : E_CRD;
                end
            end
            E_CRD:
            begin
                req.rd_en  = 1'b1;
                state_next = E_CCHK;
            end
            E_CCHK:
            begin
                if (interior && !hit)
                begin
                    base_next  = addr_reg - AB'(1) - AB'(w_reg)
                               - (three_d ? AB'(slice_reg) : '0);
                    nx_next    = '0;
                    ny_next    = '0;
                    nz_next    = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = E_NRD;
                end
                else
                begin
                    // copy through unchanged
                    req.wr_en   = 1'b1;
                    req.wr_data = src_data;
                    state_next  = E_ADV;
                end
            end
            E_NRD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = naddr;
                state_next  = E_NACC;
            end
            E_NACC:
            begin
                sum_next = sum_add;
                cnt_next = cnt_add;
                if (last_nb)
                begin
                    if (cnt_add == '0)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_data = mnmf_pkg::UNSET_CODE;
                        state_next  = E_ADV;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = E_DIV;
                    end
                end
                else
                begin
                    if (nx_reg != 2'd2)
                    begin
                        nx_next = nx_reg + 2'd1;
                    end
                    else
                    begin
                        nx_next = '0;
                        if (ny_reg != 2'd2)
                        begin
                            ny_next = ny_reg + 2'd1;
                        end
                        else
                        begin
                            ny_next = '0;
                            nz_next = nz_reg + 2'd1;
                        end
                    end
                    state_next = E_NRD;
                end
            end
            E_DIV:
            begin
                if (div_done)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_data = div_q[mnmf_pkg::VALUE_BITS-1:0];
                    state_next  = E_ADV;
                end
            end
            E_ADV:
            begin
                if (addr_reg == mnmf_pkg::ADDR_LAST)
                begin
                    bank_next = !bank_reg;
                    pass_next = pass_reg - mnmf_pkg::PASS_BITS'(1);
                    addr_next = '0;
                    x_next    = '0;
                    y_next    = '0;
                    z_next    = '0;
                    state_next = (pass_reg == mnmf_pkg::PASS_BITS'(1)) ? E_DONE : E_CRD;
                end
                else
                begin
                    addr_next = addr_reg + AB'(1);
                    // raster counters stop once past the last slice in use
                    if (z_reg < d_reg)
                    begin
                        if (x_ext + DB'(1) == w_reg)
                        begin
                            x_next = '0;
                            if (y_ext + DB'(1) == h_reg)
                            begin
                                y_next = '0;
                                z_next = z_reg + DB'(1);
                            end
                            else
                            begin
                                y_next = y_reg + CB'(1);
                            end
                        end
                        else
                        begin
                            x_next = x_reg + CB'(1);
                        end
                    end
                    state_next = E_CRD;
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            bank_reg  <= 1'b0;
            pass_reg  <= '0;
            addr_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            nx_reg    <= '0;
            ny_reg    <= '0;
            nz_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            pass_reg  <= pass_next;
            addr_reg  <= addr_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            nz_reg    <= nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        h_reg     <= h_next;
        d_reg     <= d_next;
        slice_reg <= slice_next;
        base_reg  <= base_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
    end

    assign bank = bank_reg;
    assign busy = state_reg != E_IDLE;
    assign done = state_reg == E_DONE;

endmodule

### dv/masked_neighbour_mean_fill_core_tb.sv
// ----------------------------------------------------------------------------
// masked_neighbour_mean_fill_core_tb: self-checking bench for the fill core
// Loads small volumes, runs fill passes in 3D and 2D windows and reads the
// voxels back. A predictor in the bench keeps its own two banks and registers
// and works out every read value and run answer; a checker compares each
// strobed result with the oldest expected one.
// ----------------------------------------------------------------------------
module masked_neighbour_mean_fill_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = mnmf_pkg::MAX_DIM;
    localparam int VALUE_BITS  = mnmf_pkg::VALUE_BITS;
    localparam int ADDR_BITS   = mnmf_pkg::ADDR_BITS;
    localparam int STORE_WORDS = MAX_DIM * MAX_DIM * MAX_DIM;

    localparam logic [VALUE_BITS-1:0] UNSET_CODE = mnmf_pkg::UNSET_CODE;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  ends_run;
    } answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            kind;
    logic [ADDR_BITS-1:0]  voxel_addr;
    logic [VALUE_BITS-1:0] voxel_value;
    logic                  done;
    logic [VALUE_BITS-1:0] read_value;
    logic                  run_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [7:0]            cfg_data;

    masked_neighbour_mean_fill_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .voxel_addr  (voxel_addr),
        .voxel_value (voxel_value),
        .done        (done),
        .read_value  (read_value),
        .run_done    (run_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // predictor state
    bit [VALUE_BITS-1:0] voxel_bank [2][STORE_WORDS];
    bit                  written_map [STORE_WORDS];
    int unsigned         written_list [$];
    bit                  live_bank;
    int unsigned         dim_w;
    int unsigned         dim_h;
    int unsigned         dim_d;
    int unsigned         passes;

    answer_t     answer_q [$];
    int unsigned mismatches;
    int unsigned sender_idle_pct;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #200_000_000;
        $display("masked_neighbour_mean_fill_core_tb: FAIL");
        $finish;
    end

    function automatic int unsigned sat_dim(int unsigned v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    task automatic fill_sweep();
        int unsigned w;
        int unsigned h;
        int unsigned d;
        int unsigned sl;
        int unsigned z_lo;
        int unsigned z_hi;
        int unsigned ctr;
        int unsigned sum;
        int unsigned cnt;
        int unsigned zl;
        int unsigned zh;
        bit          src;
        bit [VALUE_BITS-1:0] v;
        src = live_bank;
        w = sat_dim(dim_w);
        h = sat_dim(dim_h);
        d = sat_dim(dim_d);
        sl = w * h;
        z_lo = (d > 2) ? 1 : 0;
        z_hi = (d > 2) ? d - 1 : d;
        for (int i = 0; i < STORE_WORDS; i++)
        begin
            voxel_bank[!src][i] = voxel_bank[src][i];
        end
        if (w >= 3 && h >= 3)
        begin
            for (int unsigned z = z_lo; z < z_hi; z++)
            begin
                for (int unsigned y = 1; y + 1 < h; y++)
                begin
                    for (int unsigned x = 1; x + 1 < w; x++)
                    begin
                        ctr = x + y * w + z * sl;
                        if (voxel_bank[src][ctr] == UNSET_CODE)
                        begin
                            sum = 0;
                            cnt = 0;
                            zl = (d > 2) ? z - 1 : z;
                            zh = (d > 2) ? z + 1 : z;
                            for (int unsigned zz = zl; zz <= zh; zz++)
                                for (int unsigned yy = y - 1; yy <= y + 1; yy++)
                                    for (int unsigned xx = x - 1; xx <= x + 1; xx++)
                                    begin
                                        v = voxel_bank[src][xx + yy * w + zz * sl];
                                        if (v != UNSET_CODE)
                                        begin
                                            sum += v;
                                            cnt++;
                                        end
                                    end
                            if (cnt != 0)
                                voxel_bank[!src][ctr] = VALUE_BITS'(sum / cnt);
                        end
                    end
                end
            end
        end
        live_bank = !src;
    endtask

    task automatic predict_item(mnmf_pkg::kind_t k, int unsigned a, bit [VALUE_BITS-1:0] v);
        answer_t ans;
        case (k)
            mnmf_pkg::KIND_WRITE:
            begin
                voxel_bank[live_bank][a] = v;
                if (!written_map[a])
                begin
                    written_map[a] = 1'b1;
                    written_list.push_back(a);
                end
            end
            mnmf_pkg::KIND_RUN:
            begin
                for (int unsigned p = 0; p < passes; p++)
                    fill_sweep();
                ans.value = '0;
                ans.ends_run = 1'b1;
                answer_q.push_back(ans);
            end
            mnmf_pkg::KIND_READ:
            begin
                ans.value = voxel_bank[live_bank][a];
                ans.ends_run = 1'b0;
                answer_q.push_back(ans);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_value=%h run_done=%b",
                             read_value, run_done);
            end
            else
            begin
                want = answer_q.pop_front();
                if (read_value !== want.value || run_done !== want.ends_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: read_value exp %h got %h, run_done exp %b got %b",
                                 want.value, read_value, want.ends_run, run_done);
                end
            end
        end
    end

    task automatic hold_off();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < sender_idle_pct)
            hold_off();
    endtask

    // start stays high after acceptance; whoever waits next lowers it
    task automatic send_item(mnmf_pkg::kind_t k, int unsigned a, bit [VALUE_BITS-1:0] v);
        sender_gap();
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        voxel_addr <= ADDR_BITS'(a);
        voxel_value <= v;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_item(k, a, v);
    endtask

    task automatic wait_drained();
        hold_off();
        while (answer_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(mnmf_pkg::reg_idx_t idx, bit [7:0] data);
        wait_drained();
        repeat (10) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            mnmf_pkg::REG_WIDTH:  dim_w = data[6:0];
            mnmf_pkg::REG_HEIGHT: dim_h = data[6:0];
            mnmf_pkg::REG_DEPTH:  dim_d = data[6:0];
            default:              passes = data;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(int unsigned w, int unsigned h, int unsigned d, int unsigned p);
        write_reg(mnmf_pkg::REG_WIDTH, 8'(w));
        write_reg(mnmf_pkg::REG_HEIGHT, 8'(h));
        write_reg(mnmf_pkg::REG_DEPTH, 8'(d));
        write_reg(mnmf_pkg::REG_PASSES, 8'(p));
    endtask

    function automatic bit [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return UNSET_CODE;
            default: return VALUE_BITS'($urandom());
        endcase
    endfunction

    // write every voxel of the volume in use, then run and read it all back
    task automatic fill_and_check(int unsigned w, int unsigned h, int unsigned d,
                                  int unsigned unset_pct);
        int unsigned n;
        n = w * h * d;
        for (int unsigned a = 0; a < n; a++)
            send_item(mnmf_pkg::KIND_WRITE, a,
                      ($urandom_range(99) < unset_pct) ? UNSET_CODE : pick_value());
        send_item(mnmf_pkg::KIND_RUN, $urandom_range(STORE_WORDS - 1),
                  VALUE_BITS'($urandom()));
        for (int unsigned a = 0; a < n; a++)
            send_item(mnmf_pkg::KIND_READ, a, VALUE_BITS'($urandom()));
    endtask

    task automatic test_access_extremes();
        send_item(mnmf_pkg::KIND_WRITE, 0, '0);
        send_item(mnmf_pkg::KIND_WRITE, STORE_WORDS - 1, '1);
        send_item(mnmf_pkg::KIND_WRITE, 1, UNSET_CODE);
        send_item(mnmf_pkg::KIND_NONE, 0, 16'h1234);
        send_item(mnmf_pkg::KIND_READ, 0, '1);
        send_item(mnmf_pkg::KIND_READ, STORE_WORDS - 1, '0);
        send_item(mnmf_pkg::KIND_READ, 1, '0);
        send_item(mnmf_pkg::KIND_WRITE, STORE_WORDS - 1, 16'h5a5a);
        send_item(mnmf_pkg::KIND_READ, STORE_WORDS - 1, '0);
    endtask

    task automatic test_fill_3d();
        set_shape(4, 3, 3, 2);
        fill_and_check(4, 3, 3, 50);
    endtask

    task automatic test_fill_2d();
        set_shape(4, 4, 2, 1);
        fill_and_check(4, 4, 2, 85);
    endtask

    // no interior voxels, zero passes, oversized dimensions
    task automatic test_degenerate();
        set_shape(127, 2, 0, 0);
        send_item(mnmf_pkg::KIND_RUN, 0, '0);
        send_item(mnmf_pkg::KIND_READ, 0, '0);
        write_reg(mnmf_pkg::REG_DEPTH, 8'd1);
        write_reg(mnmf_pkg::REG_PASSES, 8'd255);
        send_item(mnmf_pkg::KIND_WRITE, 7, 16'h0001);
        send_item(mnmf_pkg::KIND_READ, 7, '0);
        write_reg(mnmf_pkg::REG_PASSES, 8'd0);
        write_reg(mnmf_pkg::REG_HEIGHT, 8'd64);
        write_reg(mnmf_pkg::REG_DEPTH, 8'd64);
        send_item(mnmf_pkg::KIND_RUN, STORE_WORDS - 1, '1);
        send_item(mnmf_pkg::KIND_READ, STORE_WORDS - 1, '0);
    endtask

    task automatic test_random(int unsigned idle_pct, int unsigned count);
        int unsigned r;
        int unsigned a;
        sender_idle_pct = idle_pct;
        set_shape($urandom_range(127, 3), $urandom_range(127, 3), $urandom_range(127), 0);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            r = $urandom_range(99);
            if (r < 60 || written_list.size() == 0)
            begin
                a = $urandom_range(STORE_WORDS - 1);
                send_item(mnmf_pkg::KIND_WRITE, a, pick_value());
            end
            else if (r < 94)
            begin
                a = written_list[$urandom_range(written_list.size() - 1)];
                send_item(mnmf_pkg::KIND_READ, a, VALUE_BITS'($urandom()));
            end
            else if (r < 97)
                send_item(mnmf_pkg::KIND_RUN, $urandom_range(STORE_WORDS - 1),
                          VALUE_BITS'($urandom()));
            else
                send_item(mnmf_pkg::KIND_NONE, $urandom_range(STORE_WORDS - 1),
                          VALUE_BITS'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = mnmf_pkg::KIND_WRITE;
        voxel_addr = '0;
        voxel_value = '0;
        cfg_valid = 1'b0;
        cfg_index = mnmf_pkg::REG_WIDTH;
        cfg_data = '0;
        live_bank = 1'b0;
        dim_w = 64;
        dim_h = 64;
        dim_d = 64;
        passes = 5;
        mismatches = 0;
        sender_idle_pct = 14;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_access_extremes();
        test_fill_3d();
        test_fill_2d();
        test_degenerate();
        test_random(14, 630);
        test_random(88, 630);
        test_random(0, 640);

        wait_drained();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("masked_neighbour_mean_fill_core_tb: PASS");
        else
            $display("masked_neighbour_mean_fill_core_tb: FAIL");
        $finish;
    end

endmodule
